>>> design/imadec_pkg.sv
// Shared constants, result and channel-state types, and the IMA ADPCM step
// table and nibble decode function for the WAV IMA ADPCM block decoder.
// No dependencies.
package imadec_pkg;

    localparam int MAX_CHANNELS    = 8;
    localparam int MAX_BLOCK_BYTES = 4096;

    localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NCH_W   = $clog2(MAX_CHANNELS + 1);
    localparam int POS_W   = $clog2(MAX_BLOCK_BYTES);
    localparam int LEN_W   = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int WORD_W  = POS_W - 2;
    localparam int FRAME_W = 13;
    localparam int IDX_W   = 7;
    localparam int IDX_MAX = 88;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_CH_W   = 4;
    localparam int CFG_BB_W   = 13;
    localparam int MIN_BLOCK_BYTES = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 8'd1;

    // Byte lanes of a channel header
    localparam logic [1:0] LANE_PRED_LO  = 2'd0;
    localparam logic [1:0] LANE_PRED_HI  = 2'd1;
    localparam logic [1:0] LANE_STEP_IDX = 2'd2;
    localparam logic [1:0] LANE_RESERVED = 2'd3;

    typedef struct packed {
        logic signed [15:0]   sample;
        logic [CH_W-1:0]      channel;
        logic [FRAME_W-1:0]   frame_index;
        logic                 last_of_byte;
        logic                 block_end;
    } t_result;

    typedef struct packed {
        logic signed [15:0] pred;
        logic [IDX_W-1:0]   idx;
    } t_chan_state;

    function automatic logic [14:0] step_size(input logic [IDX_W-1:0] idx);
        logic [14:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;   // index 88, and any index above clamps to it
        endcase
        return s;
    endfunction

    // One IMA ADPCM nibble: predictor update with 16-bit saturation,
    // step index update clamped to the table range.
    function automatic t_chan_state decode_nibble(input t_chan_state s,
                                                  input logic [3:0]  nib);
        logic [14:0]        step;
        logic [15:0]        diff;
        logic signed [17:0] base;
        logic signed [17:0] sum;
        logic signed [7:0]  adj;
        logic signed [7:0]  nidx;
        t_chan_state        r;
        step = step_size(s.idx);
        diff = 16'(step >> 3);
        if (nib[2]) diff = diff + 16'(step);
        if (nib[1]) diff = diff + 16'(step >> 1);
        if (nib[0]) diff = diff + 16'(step >> 2);
        base = 18'(s.pred);
        sum  = nib[3] ? base - $signed({2'b00, diff}) : base + $signed({2'b00, diff});
        if (sum > 18'sd32767)
            r.pred = 16'sh7fff;
        else if (sum < -18'sd32768)
            r.pred = 16'sh8000;
        else
            r.pred = sum[15:0];
        adj  = nib[2] ? ($signed({5'b00000, nib[1:0], 1'b0}) + 8'sd2) : -8'sd1;
        nidx = $signed({1'b0, s.idx}) + adj;
        if (nidx < 8'sd0)
            r.idx = '0;
        else if (nidx > 8'(IDX_MAX))
            r.idx = IDX_W'(IDX_MAX);
        else
            r.idx = nidx[IDX_W-1:0];
        return r;
    endfunction

endpackage

>>> design/ima_adpcm_block_decoder.sv
// Top level of the WAV IMA ADPCM block decoder: block position tracking,
// per-channel predictor/step-index state and the two-nibble decode datapath.
// Depends on imadec_pkg.
//
//  Channel   Handshake                 Payload                          Per transaction
//  --------  ------------------------  -------------------------------  ----------------------
//  input     i_valid / o_ready         i_data_byte                      one block byte
//  result    o_valid / i_ready         o_sample, o_channel,             one decoded sample
//                                      o_frame_index, o_last_of_byte,
//                                      o_block_end
//  config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data          one register write
//
// Header bytes only update channel state; a data byte makes two samples,
// and the result port hands out one sample per cycle while i_ready is high.
// An accepted byte is registered in the decode stage, its samples in the result buffer.
// Reset (synchronous, active low) sets channels = 1, block_bytes = 512,
// clears all predictors and step indices and restarts the block.
// A stalled result port fills the two-entry result buffer and then holds the
// decode stage; header bytes still drain the decode stage while results wait.
module ima_adpcm_block_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // byte input
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_data_byte,
    // sample output
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [15:0]                o_sample,
    output logic [imadec_pkg::CH_W-1:0]       o_channel,
    output logic [imadec_pkg::FRAME_W-1:0]    o_frame_index,
    output logic                              o_last_of_byte,
    output logic                              o_block_end,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [imadec_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [imadec_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import imadec_pkg::*;

    // configuration
    logic [CFG_CH_W-1:0] r_channels;
    logic [CFG_BB_W-1:0] r_block_bytes;

    // block bookkeeping, advanced as each byte is accepted unless any config write lands in that cycle
    logic [POS_W-1:0]  r_pos;
    logic [CH_W-1:0]   r_dch;
    logic [WORD_W-1:0] r_word;

    // decode stage: the accepted byte and where it sits in the block
    logic               r_s_valid;
    logic [7:0]         r_s_byte;
    logic               r_s_hdr;
    logic [1:0]         r_s_lane;
    logic [CH_W-1:0]    r_s_ch;
    logic [FRAME_W-1:0] r_s_frame;
    logic               r_s_last;

    // per-channel decoder state
    logic signed [15:0] r_pred [MAX_CHANNELS];
    logic [IDX_W-1:0]   r_idx  [MAX_CHANNELS];

    // result buffer: head drives the port, second holds the high nibble
    logic    r_o_valid;
    logic    r_q_valid;
    t_result r_o;
    t_result r_q;

    logic [NCH_W-1:0] eff_ch;
    logic [LEN_W-1:0] eff_len;
    logic             in_fire;
    logic             in_hdr;
    logic             in_last;
    logic [1:0]       in_lane;
    logic             out_pop;
    logic             s_fire;
    logic             cfg_fire;
    t_chan_state      cur_st;
    t_chan_state      st_lo;
    t_chan_state      st_hi;
    t_result          res_lo;
    t_result          res_hi;

    // Clamp the raw register values to the supported range.
    always_comb begin
        if (r_channels == '0)
            eff_ch = NCH_W'(1);
        else if (int'(r_channels) > MAX_CHANNELS)
            eff_ch = NCH_W'(MAX_CHANNELS);
        else
            eff_ch = NCH_W'(r_channels);

        if (int'(r_block_bytes) < MIN_BLOCK_BYTES)
            eff_len = LEN_W'(MIN_BLOCK_BYTES);
        else if (int'(r_block_bytes) > MAX_BLOCK_BYTES)
            eff_len = LEN_W'(MAX_BLOCK_BYTES);
        else
            eff_len = LEN_W'(r_block_bytes);
    end

    assign in_lane = r_pos[1:0];
    assign in_hdr  = r_pos < (POS_W'(eff_ch) << 2);
    assign in_last = (LEN_W'(r_pos) + LEN_W'(1)) >= eff_len;

    assign out_pop = r_o_valid && i_ready;
    // Header bytes only touch state; data bytes need the whole result buffer.
    assign s_fire  = r_s_valid && (r_s_hdr || (!r_q_valid && (!r_o_valid || out_pop)));
    assign o_ready = !r_s_valid || s_fire;
    assign in_fire = i_valid && o_ready;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;

    // Two chained nibble decodes, low nibble first, on the channel's state.
    always_comb begin
        cur_st.pred = r_pred[r_s_ch];
        cur_st.idx  = r_idx[r_s_ch];
        st_lo       = decode_nibble(cur_st, r_s_byte[3:0]);
        st_hi       = decode_nibble(st_lo, r_s_byte[7:4]);

        res_lo.sample       = st_lo.pred;
        res_lo.channel      = r_s_ch;
        res_lo.frame_index  = r_s_frame;
        res_lo.last_of_byte = 1'b0;
        res_lo.block_end    = r_s_last;

        res_hi.sample       = st_hi.pred;
        res_hi.channel      = r_s_ch;
        res_hi.frame_index  = r_s_frame | FRAME_W'(1);
        res_hi.last_of_byte = 1'b1;
        res_hi.block_end    = r_s_last;
    end

    // Control state: configuration, bookkeeping counters, valid flags, stores.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels    <= CFG_CH_W'(1);
            r_block_bytes <= CFG_BB_W'(512);
            r_pos         <= '0;
            r_dch         <= '0;
            r_word        <= '0;
            r_s_valid     <= 1'b0;
            r_o_valid     <= 1'b0;
            r_q_valid     <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_pred[i] <= '0;
                r_idx[i]  <= '0;
            end
        end else begin
            if (cfg_fire) begin
                unique case (i_cfg_index)
                    REG_CHANNELS: begin
                        r_channels <= i_cfg_data[CFG_CH_W-1:0];
                        r_pos      <= '0;
                        r_dch      <= '0;
                        r_word     <= '0;
                    end
                    REG_BLOCK_BYTES: begin
                        r_block_bytes <= i_cfg_data[CFG_BB_W-1:0];
                        r_pos         <= '0;
                        r_dch         <= '0;
                        r_word        <= '0;
                    end
                    default: ;  // drop writes to unknown registers
                endcase
            end else if (in_fire) begin
                // advance the block position; wrap at the block's last byte
                if (in_last)
                    r_pos <= '0;
                else
                    r_pos <= r_pos + POS_W'(1);
                if (in_last) begin
                    r_dch  <= '0;
                    r_word <= '0;
                end else if (!in_hdr && in_lane == LANE_RESERVED) begin
                    // end of a data word: rotate to the next channel
                    if ((NCH_W'(r_dch) + NCH_W'(1)) >= eff_ch) begin
                        r_dch  <= '0;
                        r_word <= r_word + WORD_W'(1);
                    end else begin
                        r_dch <= r_dch + CH_W'(1);
                    end
                end
            end

            if (in_fire)
                r_s_valid <= 1'b1;
            else if (s_fire)
                r_s_valid <= 1'b0;

            if (s_fire) begin
                if (r_s_hdr) begin
                    case (r_s_lane)
                        LANE_PRED_LO:  r_pred[r_s_ch][7:0]  <= r_s_byte;
                        LANE_PRED_HI:  r_pred[r_s_ch][15:8] <= r_s_byte;
                        LANE_STEP_IDX: r_idx[r_s_ch] <= (int'(r_s_byte) > IDX_MAX) ?
                                                        IDX_W'(IDX_MAX) :
                                                        r_s_byte[IDX_W-1:0];
                        default: ;  // reserved header byte
                    endcase
                end else begin
                    r_pred[r_s_ch] <= st_hi.pred;
                    r_idx[r_s_ch]  <= st_hi.idx;
                end
            end

            if (s_fire && !r_s_hdr) begin
                r_o_valid <= 1'b1;
                r_q_valid <= 1'b1;
            end else if (out_pop) begin
                r_o_valid <= r_q_valid;
                r_q_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s_byte  <= i_data_byte;
            r_s_hdr   <= in_hdr;
            r_s_lane  <= in_lane;
            r_s_ch    <= in_hdr ? r_pos[CH_W+1:2] : r_dch;
            r_s_frame <= (FRAME_W'(r_word) << 3) | (FRAME_W'(in_lane) << 1);
            r_s_last  <= in_last;
        end
        if (s_fire && !r_s_hdr) begin
            r_o <= res_lo;
            r_q <= res_hi;
        end else if (out_pop) begin
            r_o <= r_q;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_sample       = r_o.sample;
    assign o_channel      = r_o.channel;
    assign o_frame_index  = r_o.frame_index;
    assign o_last_of_byte = r_o.last_of_byte;
    assign o_block_end    = r_o.block_end;

endmodule

>>> design/imadec_chk.sv
// Port-level checker for the IMA ADPCM block decoder and its bind statement.
// Depends on imadec_pkg and ima_adpcm_block_decoder.
module imadec_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic signed [15:0]                o_sample,
    input logic [imadec_pkg::CH_W-1:0]       o_channel,
    input logic [imadec_pkg::FRAME_W-1:0]    o_frame_index,
    input logic                              o_last_of_byte,
    input logic                              o_block_end
);
    import imadec_pkg::*;

    // hold a stalled result steady
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample) && $stable(o_channel)
                                && $stable(o_frame_index) && $stable(o_last_of_byte)
                                && $stable(o_block_end))
        else $error("result changed while stalled");

    // the high-nibble sample follows its low nibble at once
    a_pair_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_byte |=> o_valid && o_last_of_byte)
        else $error("high nibble sample missing after low nibble");

    // both samples of a byte share channel, block end, and adjacent frames
    a_pair_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_byte |=>
            o_channel == $past(o_channel) && o_block_end == $past(o_block_end)
            && o_frame_index == ($past(o_frame_index) + FRAME_W'(1)))
        else $error("sample pair does not match");

    // reset empties the result buffer
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind ima_adpcm_block_decoder imadec_chk u_imadec_chk (.*);

>>> dv/tb_ima_adpcm_block_decoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for the WAV IMA ADPCM block decoder: feeds block bytes, predicts
// every decoded sample and checks the sample stream field by field.
// Depends on imadec_pkg and the ima_adpcm_block_decoder RTL.
module tb_ima_adpcm_block_decoder;
    import imadec_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 8;      // well past the decode stage and result buffer
    localparam int RANDOM_BYTES = 180;
    localparam int MAX_REPORTS  = 10;

    // Write indexes outside the register list, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_BLOCK_BYTES + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

    // Standard IMA ADPCM step sizes, one per step index
    localparam int STEP_SIZES [89] = '{
        7, 8, 9, 10, 11, 12, 13, 14, 16, 17,
        19, 21, 23, 25, 28, 31, 34, 37, 41, 45,
        50, 55, 60, 66, 73, 80, 88, 97, 107, 118,
        130, 143, 157, 173, 190, 209, 230, 253, 279, 307,
        337, 371, 408, 449, 494, 544, 598, 658, 724, 796,
        876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066,
        2272, 2499, 2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358,
        5894, 6484, 7132, 7845, 8630, 9493, 10442, 11487, 12635, 13899,
        15289, 16818, 18500, 20350, 22385, 24623, 27086, 29794, 32767
    };

    // Step index change indexed by the magnitude bits of a nibble
    localparam int IDX_STEP [8] = '{-1, -1, -1, -1, 2, 4, 6, 8};

    // One directed byte; where typed is set, the two samples are given here
    typedef struct packed {
        logic [7:0]  data;
        logic        typed;
        logic [15:0] lo;
        logic [15:0] hi;
    } t_dir_row;

    // Three 8-byte blocks of one channel: a header, then one data word each.
    // Block B pins the predictor at full scale with the step index clamped,
    // block C at negative full scale; all sixteen nibble codes appear.
    localparam t_dir_row DIRECTED_ROWS [24] = '{
        '{8'h00, 1'b0, 16'h0000, 16'h0000},
        '{8'h00, 1'b0, 16'h0000, 16'h0000},
        '{8'h00, 1'b0, 16'h0000, 16'h0000},
        '{8'hA5, 1'b0, 16'h0000, 16'h0000},     // reserved byte, ignored
        '{8'h00, 1'b1, 16'h0000, 16'h0000},
        '{8'h88, 1'b1, 16'h0000, 16'h0000},     // zero step, sign bit alone
        '{8'h77, 1'b0, 16'h0000, 16'h0000},
        '{8'h9A, 1'b0, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 16'h0000, 16'h0000},
        '{8'h7F, 1'b0, 16'h0000, 16'h0000},
        '{8'hC8, 1'b0, 16'h0000, 16'h0000},     // step index 200 clamps to 88
        '{8'h00, 1'b0, 16'h0000, 16'h0000},
        '{8'h77, 1'b1, 16'h7FFF, 16'h7FFF},     // saturates high
        '{8'hDB, 1'b0, 16'h0000, 16'h0000},
        '{8'h80, 1'b0, 16'h0000, 16'h0000},
        '{8'h3C, 1'b0, 16'h0000, 16'h0000},
        '{8'h00, 1'b0, 16'h0000, 16'h0000},
        '{8'h80, 1'b0, 16'h0000, 16'h0000},
        '{8'h58, 1'b0, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, 16'h0000, 16'h0000},
        '{8'hFF, 1'b1, 16'h8000, 16'h8000},     // saturates low
        '{8'hE2, 1'b0, 16'h0000, 16'h0000},
        '{8'h41, 1'b0, 16'h0000, 16'h0000},
        '{8'h56, 1'b0, 16'h0000, 16'h0000}
    };

    typedef enum logic [1:0] {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} t_sink_mode;

    // DUT ports
    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [7:0]              i_data_byte;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic signed [15:0]      o_sample;
    logic [CH_W-1:0]         o_channel;
    logic [FRAME_W-1:0]      o_frame_index;
    logic                    o_last_of_byte;
    logic                    o_block_end;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    // Decoder state as the predictor sees it
    logic [CFG_CH_W-1:0]     reg_channels;
    logic [CFG_BB_W-1:0]     reg_block_bytes;
    logic signed [15:0]      pred_st [MAX_CHANNELS];
    int                      step_ix [MAX_CHANNELS];
    int                      blk_pos;
    int                      word_ch;
    int                      word_cnt;

    t_result                 expected_samples [$];
    int                      mismatches  = 0;
    int                      cycle_count = 0;
    int                      burst_left  = 0;
    t_sink_mode              sink_mode   = SINK_OPEN;
    int                      sink_tick   = 0;

    ima_adpcm_block_decoder uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample       (o_sample),
        .o_channel      (o_channel),
        .o_frame_index  (o_frame_index),
        .o_last_of_byte (o_last_of_byte),
        .o_block_end    (o_block_end),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Channel count in use: zero acts as one, anything above the maximum saturates
    function automatic int eff_channels();
        if (reg_channels == 0) return 1;
        if (reg_channels > MAX_CHANNELS) return MAX_CHANNELS;
        return int'(reg_channels);
    endfunction

    function automatic int eff_block_len();
        if (reg_block_bytes < MIN_BLOCK_BYTES) return MIN_BLOCK_BYTES;
        if (reg_block_bytes > MAX_BLOCK_BYTES) return MAX_BLOCK_BYTES;
        return int'(reg_block_bytes);
    endfunction

    // Back to the first header byte; predictors and step indices are kept
    function automatic void restart_block();
        blk_pos  = 0;
        word_ch  = 0;
        word_cnt = 0;
    endfunction

    // Decode one nibble for a channel and advance that channel's state
    function automatic logic signed [15:0] ima_nibble(input int ch, input logic [3:0] nib);
        int step, diff, acc, ix;
        ix   = step_ix[ch];
        step = STEP_SIZES[ix];
        diff = step >> 3;
        if (nib[2]) diff += step;
        if (nib[1]) diff += step >> 1;
        if (nib[0]) diff += step >> 2;
        acc = pred_st[ch];
        acc = nib[3] ? acc - diff : acc + diff;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        ix += IDX_STEP[nib[2:0]];
        if (ix < 0) ix = 0;
        if (ix > IDX_MAX) ix = IDX_MAX;
        pred_st[ch] = acc[15:0];
        step_ix[ch] = ix;
        return acc[15:0];
    endfunction

    // Take one block byte; return the number of samples it makes (0 or 2)
    function automatic int ima_decode_byte(input logic [7:0] b, output t_result lo,
                                           output t_result hi);
        int nch, len, ch, lane, frame, n;
        bit is_last;
        nch     = eff_channels();
        len     = eff_block_len();
        lane    = blk_pos % 4;
        is_last = (blk_pos + 1 >= len);
        n       = 0;
        lo      = '0;
        hi      = '0;
        if (blk_pos < 4 * nch) begin
            ch = (blk_pos / 4) % MAX_CHANNELS;
            case (lane)
                LANE_PRED_LO:  pred_st[ch][7:0]  = b;
                LANE_PRED_HI:  pred_st[ch][15:8] = b;
                LANE_STEP_IDX: step_ix[ch] = (b > IDX_MAX) ? IDX_MAX : int'(b);
                default: ;                          // reserved byte
            endcase
        end else begin
            ch    = word_ch % MAX_CHANNELS;
            frame = word_cnt * 8 + lane * 2;
            lo.sample       = ima_nibble(ch, b[3:0]);
            lo.channel      = CH_W'(ch);
            lo.frame_index  = FRAME_W'(frame);
            lo.last_of_byte = 1'b0;
            lo.block_end    = is_last;
            hi.sample       = ima_nibble(ch, b[7:4]);
            hi.channel      = CH_W'(ch);
            hi.frame_index  = FRAME_W'(frame + 1);
            hi.last_of_byte = 1'b1;
            hi.block_end    = is_last;
            n = 2;
            // Rotate to the next channel after each full data word
            if (lane == LANE_RESERVED) begin
                if (word_ch + 1 >= nch) begin
                    word_ch = 0;
                    word_cnt++;
                end else begin
                    word_ch++;
                end
            end
        end
        if (is_last) restart_block();
        else blk_pos++;
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one byte in bursts with random gaps; queue the samples it makes.
    // Typed rows replace the predicted sample values with the listed ones.
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input logic [15:0] lo_sample, input logic [15:0] hi_sample);
        t_result lo, hi;
        int      n;
        int      gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
        n = ima_decode_byte(b, lo, hi);
        if (n == 2) begin
            if (typed) begin
                lo.sample = lo_sample;
                hi.sample = hi_sample;
            end
            expected_samples.push_back(lo);
            expected_samples.push_back(hi);
        end
    endtask

    // Hold until every queued sample has come out, then let the pipe drain
    task automatic wait_idle();
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write transaction; the caller drops i_cfg_valid afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_CHANNELS: begin
                reg_channels = val[CFG_CH_W-1:0];
                restart_block();
            end
            REG_BLOCK_BYTES: begin
                reg_block_bytes = val[CFG_BB_W-1:0];
                restart_block();
            end
            default: ;
        endcase
    endtask

    // Reconfigure once the decoder is idle; the input channel must already be low
    task automatic configure(input logic [CFG_DATA_W-1:0] ch_word,
                             input logic [CFG_DATA_W-1:0] bb_word, input bit junk);
        wait_idle();
        if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_CHANNELS, ch_word);
            write_reg(REG_BLOCK_BYTES, bb_word);
        end else begin
            write_reg(REG_BLOCK_BYTES, bb_word);
            write_reg(REG_CHANNELS, ch_word);
        end
        if (junk)
            write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                      CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // One phase: configure, then stream random block content
    task automatic run_phase(input logic [CFG_DATA_W-1:0] ch_word,
                             input logic [CFG_DATA_W-1:0] bb_word,
                             input int nbytes, input bit junk);
        logic [7:0] b;
        configure(ch_word, bb_word, junk);
        for (int i = 0; i < nbytes; i++) begin
            b = 8'($urandom_range(0, 255));
            // Keep most header step indices in range so decoding covers the whole table
            if (blk_pos < 4 * eff_channels() && blk_pos % 4 == LANE_STEP_IDX &&
                $urandom_range(0, 7) != 0)
                b = 8'($urandom_range(0, IDX_MAX));
            send_byte(b, 1'b0, '0, '0);
        end
        i_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sample sink: stall pattern mode is redrawn at random as sink_tick counts cycles
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        sink_tick <= sink_tick + 1;
        if (sink_tick % 300 == 0) sink_mode <= t_sink_mode'($urandom_range(0, 3));
        case (sink_mode)
            SINK_OPEN:  i_ready <= 1'b1;
            SINK_LIGHT: i_ready <= ($urandom_range(0, 3) != 0);
            SINK_HEAVY: i_ready <= ($urandom_range(0, 3) == 0);
            default:    i_ready <= (sink_tick % 5 != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Sample checker: compare each transaction with the oldest expected sample
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : sample_check
        t_result got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_sample, o_channel, o_frame_index, o_last_of_byte, o_block_end};
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected sample %0d ch %0d frame %0d hi %0b end %0b",
                             $realtime, got.sample, got.channel, got.frame_index,
                             got.last_of_byte, got.block_end);
            end else begin
                want = expected_samples.pop_front();
                if (got.sample !== want.sample || got.channel !== want.channel ||
                    got.frame_index !== want.frame_index ||
                    got.last_of_byte !== want.last_of_byte ||
                    got.block_end !== want.block_end) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] sample mismatch", $realtime);
                        $display("  expected %0d ch %0d frame %0d hi %0b end %0b",
                                 want.sample, want.channel, want.frame_index,
                                 want.last_of_byte, want.block_end);
                        $display("  actual   %0d ch %0d frame %0d hi %0b end %0b",
                                 got.sample, got.channel, got.frame_index,
                                 got.last_of_byte, got.block_end);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int                    random_sent;
        int                    nch;
        int                    nbytes;
        logic [CFG_DATA_W-1:0] ch_word;
        logic [CFG_DATA_W-1:0] bb_word;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        // Predictor starts from the reset state: one channel, 512-byte blocks
        reg_channels    = 1;
        reg_block_bytes = 512;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            pred_st[c] = '0;
            step_ix[c] = 0;
        end
        restart_block();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Run a few bytes on the reset configuration before any write
        for (int i = 0; i < 12; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0, '0, '0);
        i_valid <= 1'b0;

        // Directed blocks at the shortest block length
        configure(13'd1, 13'd8, 1'b0);
        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].lo, DIRECTED_ROWS[i].hi);
        i_valid <= 1'b0;

        // Extremes and odd block shapes
        run_phase(13'd8, 13'd4096, 80, 1'b0);     // widest, longest block
        run_phase(13'h1FFF, 13'h1FFF, 60, 1'b1);  // both registers saturate
        run_phase(13'd8, 13'd20, 45, 1'b0);       // block shorter than its headers
        run_phase(13'd3, 13'd42, 100, 1'b0);      // partial data word ends the block
        run_phase(13'd0, 13'd0, 30, 1'b1);        // zero channels, zero length

        // Random phases, each reconfigured while the decoder is idle
        random_sent = 0;
        while (random_sent < RANDOM_BYTES) begin
            nch     = $urandom_range(1, MAX_CHANNELS);
            ch_word = CFG_DATA_W'(nch);
            case ($urandom_range(0, 7))
                0: begin
                    ch_word = ($urandom_range(0, 1) == 0) ? '0
                                                          : CFG_DATA_W'($urandom_range(9, 15));
                    bb_word = CFG_DATA_W'($urandom_range(8, 96));
                end
                1: bb_word = ($urandom_range(0, 1) == 0)
                             ? CFG_DATA_W'($urandom_range(0, MIN_BLOCK_BYTES - 1))
                             : CFG_DATA_W'($urandom_range(MAX_BLOCK_BYTES + 1, 8191));
                2: bb_word = CFG_DATA_W'($urandom_range(MIN_BLOCK_BYTES, 4 * nch + 4));
                3: bb_word = CFG_DATA_W'(4 * nch * $urandom_range(2, 4) + $urandom_range(1, 3));
                default: bb_word = CFG_DATA_W'(4 * nch * $urandom_range(2, 5));
            endcase
            // Stray upper bits on the channel write must be dropped
            if ($urandom_range(0, 3) == 0)
                ch_word[CFG_DATA_W-1:CFG_CH_W] = (CFG_DATA_W - CFG_CH_W)'($urandom);
            nbytes = $urandom_range(16, 96);
            run_phase(ch_word, bb_word, nbytes, ($urandom_range(0, 5) == 0));
            random_sent += nbytes;
        end

        wait_idle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
